// ===== rtl/ppmd_pkg.sv =====
// shared types and constants of the ppm frame decoder
package ppmd_pkg;

	localparam int TICK_SCALE        = 4;
	localparam int SYNC_RESET        = 10000 / TICK_SCALE;
	localparam int STORED_CHANNELS_DEF = 8;

	localparam int TIME_W   = 16;
	localparam int IDX_W    = 5;
	localparam int FSCH_W   = 3;
	localparam int WIDTH_W  = 17;
	localparam int CNT_W    = 16;
	localparam int CHAN_W   = 4;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 3;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;

	localparam logic [TIME_W-1:0]  SYNC_THR_RST  = TIME_W'(SYNC_RESET);
	localparam logic [IDX_W-1:0]   FRAME_CH_RST  = IDX_W'(8);
	localparam logic [FSCH_W-1:0]  FS_CH_RST     = '0;
	localparam logic [WIDTH_W-1:0] FS_MIN_RST    = WIDTH_W'(1500);
	localparam logic [WIDTH_W-1:0] FS_MAX_RST    = WIDTH_W'(4500);
	localparam logic [CNT_W-1:0]   CNT_MAX       = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SYNC_THRESHOLD   = 3'd0,
		REG_FRAME_CHANNELS   = 3'd1,
		REG_FAILSAFE_CHANNEL = 3'd2,
		REG_FAILSAFE_MIN     = 3'd3,
		REG_FAILSAFE_MAX     = 3'd4
	} reg_idx_t;

	// one result, lowest field last
	typedef struct packed {
		logic [CNT_W-1:0]   noise_count;
		logic [CNT_W-1:0]   good_count;
		logic [WIDTH_W-1:0] width;
		logic [CHAN_W-1:0]  channel;
		logic               stored;
		logic               is_sync;
	} res_t;

endpackage

// ===== rtl/ppm_frame_decoder.sv =====
// top level of the ppm frame decoder
//
// ppm frame decoder: takes one 16-bit timer capture per ppm edge on the s_ side and
// gives one result per capture on the m_ side. the interval to the previous capture
// (modulo 2^16) is compared with sync_threshold; a longer gap is a frame sync and
// returns the channel index to zero, otherwise the doubled interval is written to the
// current channel while it is below frame_channels and STORED_CHANNELS, and pulses on
// the failsafe channel are sorted into saturating good and noise counters by the open
// (failsafe_min, failsafe_max) window. the interval, compares and counter updates are done
// in the accepting cycle and land in the output or skid register, so a request is taken in
// every cycle while s_tready is high; a two-deep output buffer (output
// register plus skid register) keeps s_tready registered and drops it only when both
// hold results the consumer has not yet taken. configuration is written through
// cfg_we / cfg_index / cfg_data and must only change while the block is idle.
module ppm_frame_decoder
	import ppmd_pkg::*;
#(
	parameter int STORED_CHANNELS = STORED_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	// capture requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] capture_time
	// result requests
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [3:0] channel, [20:4] width,
	                                         // [36:21] good_count, [52:37] noise_count
	output logic [OUT_USER_W-1:0] m_tuser    // [0] is_sync, [1] stored
);

	localparam logic [IDX_W:0] STORED_LIM = (IDX_W+1)'(STORED_CHANNELS);

	// configuration registers
	logic [TIME_W-1:0]  sync_threshold_q;
	logic [IDX_W-1:0]   frame_channels_q;
	logic [FSCH_W-1:0]  failsafe_channel_q;
	logic [WIDTH_W-1:0] failsafe_min_q;
	logic [WIDTH_W-1:0] failsafe_max_q;

	// decoder state
	logic [TIME_W-1:0]  last_capture_q;
	logic [IDX_W-1:0]   chan_idx_q;
	logic [CNT_W-1:0]   good_q;
	logic [CNT_W-1:0]   noise_q;

	// output buffer
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	logic               accept;
	logic [TIME_W-1:0]  interval;
	logic [WIDTH_W-1:0] width;
	logic               sync;
	logic               in_frame;
	logic               do_store;
	logic               fs_hit;
	logic               in_window;
	logic [IDX_W-1:0]   chan_idx_nxt;
	logic [CNT_W-1:0]   good_nxt;
	logic [CNT_W-1:0]   noise_nxt;
	res_t               res;

	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;

	// per-capture decode
	always_comb begin
		interval  = s_tdata[TIME_W-1:0] - last_capture_q;   // wraps with the timer
		width     = {interval, 1'b0};
		sync      = interval > sync_threshold_q;
		in_frame  = chan_idx_q < frame_channels_q;
		do_store  = !sync && in_frame && ({1'b0, chan_idx_q} < STORED_LIM);
		fs_hit    = do_store && (chan_idx_q == IDX_W'(failsafe_channel_q));
		in_window = (width > failsafe_min_q) && (width < failsafe_max_q);

		chan_idx_nxt = chan_idx_q;
		if (sync) begin
			chan_idx_nxt = '0;
		end else if (in_frame) begin
			chan_idx_nxt = chan_idx_q + IDX_W'(1);
		end

		good_nxt  = good_q;
		noise_nxt = noise_q;
		if (fs_hit) begin
			if (in_window) begin
				if (good_q != CNT_MAX) good_nxt = good_q + CNT_W'(1);
			end else begin
				if (noise_q != CNT_MAX) noise_nxt = noise_q + CNT_W'(1);
			end
		end

		res.is_sync     = sync;
		res.stored      = do_store;
		res.channel     = do_store ? chan_idx_q[CHAN_W-1:0] : '0;
		res.width       = width;
		res.good_count  = good_nxt;
		res.noise_count = noise_nxt;
	end

	// configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_threshold_q   <= SYNC_THR_RST;
			frame_channels_q   <= FRAME_CH_RST;
			failsafe_channel_q <= FS_CH_RST;
			failsafe_min_q     <= FS_MIN_RST;
			failsafe_max_q     <= FS_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_THRESHOLD:   sync_threshold_q   <= cfg_data[TIME_W-1:0];
				REG_FRAME_CHANNELS:   frame_channels_q   <= cfg_data[IDX_W-1:0];
				REG_FAILSAFE_CHANNEL: failsafe_channel_q <= cfg_data[FSCH_W-1:0];
				REG_FAILSAFE_MIN:     failsafe_min_q     <= cfg_data[WIDTH_W-1:0];
				REG_FAILSAFE_MAX:     failsafe_max_q     <= cfg_data[WIDTH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// decoder state moves on every accepted capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_capture_q <= '0;
			chan_idx_q     <= '0;
			good_q         <= '0;
			noise_q        <= '0;
		end else if (accept) begin
			last_capture_q <= s_tdata[TIME_W-1:0];
			chan_idx_q     <= chan_idx_nxt;
			good_q         <= good_nxt;
			noise_q        <= noise_nxt;
		end
	end

	// output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {out_q.stored, out_q.is_sync};
	assign m_tdata  = {3'b000, out_q.noise_count, out_q.good_count, out_q.width, out_q.channel};

endmodule

// ===== rtl/ppmd_checker.sv =====
// port-level checks of the ppm frame decoder and their binding
module ppmd_checker
	import ppmd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a sync never stores a width
	a_sync_no_store: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("sync and store in one result");

	// channel field is zero unless a width was stored
	a_chan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[3:0] == 4'd0)
		else $error("channel set without a store");

	// the scaled width is always even
	a_width_even: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[4] == 1'b0)
		else $error("odd scaled width");

endmodule

bind ppm_frame_decoder ppmd_checker u_ppmd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/ppm_frame_decoder_chk.sv =====
// checker for the ppm frame decoder: predicts each result from the captures and compares
module ppm_frame_decoder_chk
	import ppmd_pkg::*;
#(
	parameter int STORED_CHANNELS = STORED_CHANNELS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic [OUT_USER_W-1:0] m_tuser,
	output int                    error_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 10;
	localparam int WIDTH_LSB   = CHAN_W;
	localparam int GOOD_LSB    = WIDTH_LSB + WIDTH_W;
	localparam int NOISE_LSB   = GOOD_LSB + CNT_W;

	// register copies
	logic [TIME_W-1:0]  sync_thr;
	logic [IDX_W-1:0]   frame_ch;
	logic [FSCH_W-1:0]  fs_ch;
	logic [WIDTH_W-1:0] fs_min;
	logic [WIDTH_W-1:0] fs_max;

	// decoder state
	logic [TIME_W-1:0]  last_capture;
	logic [IDX_W-1:0]   chan_idx;
	logic [WIDTH_W-1:0] chan_widths [STORED_CHANNELS];
	logic [CNT_W-1:0]   good_pulses;
	logic [CNT_W-1:0]   noise_pulses;

	res_t pending_results [$];
	int   errs;

	initial begin
		error_count = 0;
		pending     = 0;
	end

	task automatic decode_capture(input logic [TIME_W-1:0] now, output res_t r);
		logic [TIME_W-1:0] gap;
		gap = now - last_capture;
		last_capture = now;
		r = '0;
		r.width = {gap, 1'b0};
		if (gap > sync_thr) begin
			r.is_sync = 1'b1;
			chan_idx  = '0;
		end else if (chan_idx < frame_ch) begin
			// channels past the stored ones only move the index on
			if (chan_idx < STORED_CHANNELS) begin
				r.stored  = 1'b1;
				r.channel = CHAN_W'(chan_idx);
				chan_widths[chan_idx] = r.width;
				if (chan_idx == IDX_W'(fs_ch)) begin
					if (r.width > fs_min && r.width < fs_max) begin
						if (good_pulses != CNT_MAX)
							good_pulses++;
					end else if (noise_pulses != CNT_MAX) begin
						noise_pulses++;
					end
				end
			end
			chan_idx = chan_idx + 1'b1;
		end
		r.good_count  = good_pulses;
		r.noise_count = noise_pulses;
	endtask

	task automatic note_field(input string field, input logic [WIDTH_W-1:0] want,
			input logic [WIDTH_W-1:0] got);
		if (want !== got) begin
			errs++;
			if (errs <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			sync_thr     = SYNC_THR_RST;
			frame_ch     = FRAME_CH_RST;
			fs_ch        = FS_CH_RST;
			fs_min       = FS_MIN_RST;
			fs_max       = FS_MAX_RST;
			last_capture = '0;
			chan_idx     = '0;
			good_pulses  = '0;
			noise_pulses = '0;
			foreach (chan_widths[i])
				chan_widths[i] = '0;
			pending_results.delete();
			errs = 0;
		end else begin
			// results first, so a result can never meet its own request in one cycle
			if (m_tvalid && m_tready) begin
				got.is_sync     = m_tuser[0];
				got.stored      = m_tuser[1];
				got.channel     = m_tdata[CHAN_W-1:0];
				got.width       = m_tdata[WIDTH_LSB +: WIDTH_W];
				got.good_count  = m_tdata[GOOD_LSB +: CNT_W];
				got.noise_count = m_tdata[NOISE_LSB +: CNT_W];
				if (pending_results.size() == 0) begin
					errs++;
					if (errs <= MAX_REPORTS)
						$display("%0t: result with nothing expected", $realtime);
				end else begin
					want = pending_results.pop_front();
					note_field("is_sync", WIDTH_W'(want.is_sync), WIDTH_W'(got.is_sync));
					note_field("stored", WIDTH_W'(want.stored), WIDTH_W'(got.stored));
					note_field("channel", WIDTH_W'(want.channel), WIDTH_W'(got.channel));
					note_field("width", want.width, got.width);
					note_field("good_count", WIDTH_W'(want.good_count),
						WIDTH_W'(got.good_count));
					note_field("noise_count", WIDTH_W'(want.noise_count),
						WIDTH_W'(got.noise_count));
				end
			end
			if (s_tvalid && s_tready) begin
				decode_capture(s_tdata[TIME_W-1:0], want);
				pending_results.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_SYNC_THRESHOLD:   sync_thr = cfg_data[TIME_W-1:0];
					REG_FRAME_CHANNELS:   frame_ch = cfg_data[IDX_W-1:0];
					REG_FAILSAFE_CHANNEL: fs_ch    = cfg_data[FSCH_W-1:0];
					REG_FAILSAFE_MIN:     fs_min   = cfg_data[WIDTH_W-1:0];
					REG_FAILSAFE_MAX:     fs_max   = cfg_data[WIDTH_W-1:0];
					default: ;
				endcase
			end
		end
		error_count <= errs;
		pending     <= pending_results.size();
	end

endmodule

// ===== tb/ppm_frame_decoder_tb.sv =====
// testbench top of the ppm frame decoder: capture stimulus, register setups and verdict
module ppm_frame_decoder_tb
	import ppmd_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 100_000;
	localparam int RANDOM_ITEMS = 700;
	// frames per setup in the closing back-to-back phase
	localparam int SOAK_FRAMES  = 32;
	localparam int MAX_GAP      = 65_535;
	localparam int FULL_FRAME   = 16;
	localparam int MAX_INDEX    = 31;
	// indexes past the register list, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct {
		logic [TIME_W-1:0]  sync_thr;
		logic [IDX_W-1:0]   frame_ch;
		logic [FSCH_W-1:0]  fs_ch;
		logic [WIDTH_W-1:0] fs_min;
		logic [WIDTH_W-1:0] fs_max;
	} decoder_setup_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;   // [3:0] channel, [20:4] width,
	                                  // [36:21] good_count, [52:37] noise_count
	logic [OUT_USER_W-1:0] m_tuser;   // [0] is_sync, [1] stored

	int error_count;
	int pending;

	// random back-pressure and source gaps, switched off for whole phases
	logic        idling     = 1'b0;
	int          stall_left = 0;
	int unsigned cycle_count = 0;

	// free-running timer as the capture unit would see it
	logic [TIME_W-1:0] timer_now = '0;

	ppm_frame_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	ppm_frame_decoder_chk chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.error_count (error_count),
		.pending     (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: stalls come in random bursts
	always @(posedge clk) begin
		if (!idling) begin
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// one capture request, gap counted in timer ticks since the previous edge
	task automatic send_after(input int gap);
		int pause;
		timer_now = timer_now + TIME_W'(gap);
		if (idling && $urandom_range(0, 3) == 0) begin
			pause = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= timer_now;
		do @(posedge clk); while (!s_tready);
	endtask

	// stop requests and let every outstanding result come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (3) @(posedge clk);
	endtask

	// narrow registers get random junk above their width
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val,
			input int bits);
		logic [CFG_W-1:0] keep;
		keep = CFG_W'((64'd1 << bits) - 1);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= (CFG_W'($urandom) & ~keep) | (val & keep);
		@(posedge clk);
	endtask

	task automatic apply_setup(input decoder_setup_t s);
		write_reg(REG_SYNC_THRESHOLD, CFG_W'(s.sync_thr), TIME_W);
		write_reg(REG_FRAME_CHANNELS, CFG_W'(s.frame_ch), IDX_W);
		write_reg(REG_FAILSAFE_CHANNEL, CFG_W'(s.fs_ch), FSCH_W);
		write_reg(REG_FAILSAFE_MIN, s.fs_min, WIDTH_W);
		write_reg(REG_FAILSAFE_MAX, s.fs_max, WIDTH_W);
		write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
			CFG_W'($urandom), CFG_W);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic decoder_setup_t pick_setup();
		decoder_setup_t s;
		int span;
		case ($urandom_range(0, 7))
			0: s.sync_thr = '0;
			1: s.sync_thr = '1;
			2: s.sync_thr = TIME_W'($urandom);
			default: s.sync_thr = TIME_W'($urandom_range(200, 5000));
		endcase
		case ($urandom_range(0, 7))
			0: s.frame_ch = '0;
			1: s.frame_ch = IDX_W'(FULL_FRAME);
			2: s.frame_ch = IDX_W'($urandom_range(FULL_FRAME + 1, MAX_INDEX));
			default: s.frame_ch = IDX_W'($urandom_range(1, FULL_FRAME));
		endcase
		s.fs_ch = FSCH_W'($urandom);
		// window mostly placed where the pulse widths land
		span = 2 * int'(s.sync_thr) + 2;
		case ($urandom_range(0, 5))
			0: begin
				s.fs_min = WIDTH_W'($urandom);
				s.fs_max = WIDTH_W'($urandom);
			end
			1: begin
				s.fs_min = '0;
				s.fs_max = '1;
			end
			default: begin
				s.fs_min = WIDTH_W'($urandom_range(0, span));
				s.fs_max = WIDTH_W'(int'(s.fs_min) + int'($urandom_range(0, span)));
			end
		endcase
		return s;
	endfunction

	// gap long enough for a frame sync, where one is possible at all
	function automatic int sync_gap(input decoder_setup_t s);
		if (s.sync_thr == '1)
			return $urandom_range(0, MAX_GAP);
		return $urandom_range(int'(s.sync_thr) + 1, MAX_GAP);
	endfunction

	// channel pulse, often right on a window edge
	function automatic int pulse_gap(input decoder_setup_t s);
		int g;
		case ($urandom_range(0, 3))
			0: g = $urandom_range(0, int'(s.sync_thr));
			1: g = int'(s.fs_min) / 2 + int'($urandom_range(0, 1));
			2: g = int'(s.fs_max) / 2 - int'($urandom_range(0, 1));
			default: g = $urandom_range(int'(s.fs_min) / 2, int'(s.fs_max) / 2);
		endcase
		if (g < 0)
			g = 0;
		if (g > int'(s.sync_thr))
			g = int'(s.sync_thr);
		return g;
	endfunction

	initial begin
		decoder_setup_t setup;
		int random_sent;
		int budget;
		int n;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames on the reset setup: threshold 2500, 8 channels, window on channel 0
		send_after(MAX_GAP);          // longest interval, sync
		send_after(1000);             // timer wraps, channel 0 inside the window
		send_after(2500);             // interval equal to the threshold is no sync
		for (int i = 1; i <= 6; i++)
			send_after(i);            // channels 2 to 7
		send_after(0);                // frame full, ignored
		send_after(100);              // still ignored
		send_after(2501);             // sync
		send_after(750);              // width equal to the minimum counts as noise
		send_after(3000);             // sync
		send_after(2250);             // width equal to the maximum counts as noise
		send_after(2249);             // channel 1, index now 2

		// frame count lowered below the index, zero threshold, window wide open
		wait_idle();
		setup = '{16'd0, 5'd1, 3'd7, 17'd0, 17'h1ffff};
		apply_setup(setup);
		send_after(0);                // index above the frame count, ignored
		send_after(7);                // any nonzero interval is a sync
		send_after(0);                // channel 0 stored, not the failsafe channel
		send_after(0);                // frame full
		send_after(MAX_GAP);

		// random setups, mostly well-formed frames with random widths
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			setup = pick_setup();
			wait_idle();
			apply_setup(setup);
			idling <= ($urandom_range(0, 3) != 0);
			budget = $urandom_range(30, 90);
			while (budget > 0) begin
				if ($urandom_range(0, 7) == 0) begin
					// noise: edges with no frame structure at all
					n = $urandom_range(1, 4);
					repeat (n) send_after($urandom_range(0, MAX_GAP));
				end else begin
					send_after(sync_gap(setup));
					// frames a little short, exact or overfull
					n = int'(setup.frame_ch) + int'($urandom_range(0, 3)) - 1;
					if (n < 0)
						n = 0;
					repeat (n) send_after(pulse_gap(setup));
					n++;
				end
				random_sent += n;
				budget -= n;
			end
		end

		// back to back with no idling: every pulse good, then every pulse noise
		idling <= 1'b0;
		wait_idle();
		setup = '{16'd1000, 5'd1, 3'd0, 17'd0, 17'h1ffff};
		apply_setup(setup);
		repeat (SOAK_FRAMES) begin
			send_after($urandom_range(1001, MAX_GAP));
			send_after($urandom_range(1, 1000));
		end
		wait_idle();
		setup = '{16'd1000, 5'd1, 3'd0, 17'h1ffff, 17'd0};
		apply_setup(setup);
		repeat (SOAK_FRAMES) begin
			send_after($urandom_range(1001, MAX_GAP));
			send_after($urandom_range(0, 1000));
		end
		wait_idle();

		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
